### hw/rtl/mpsd_pkg.sv
`timescale 1ns / 1ps

package mpsd_pkg;

    // Default geometry of the maze and of the path stack.
    localparam int GRID_DEF        = 8;
    localparam int STACK_DEPTH_DEF = 64;

    // A run never reports more path cells than this.
    localparam int MAX_RESULTS = 64;

    // Fixed field widths.
    localparam int ROW_W   = 8;
    localparam int POS_W   = 4;
    localparam int CFG_W   = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Cell codes held in the map RAM.
    localparam logic [1:0] CELL_OPEN    = 2'd0;
    localparam logic [1:0] CELL_WALL    = 2'd1;
    localparam logic [1:0] CELL_VISITED = 2'd2;

    // Search directions, tried in this order.
    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_GOAL_X  = 2'd2;
    localparam logic [1:0] REG_GOAL_Y  = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] START_X_RST = 4'd1;
    localparam logic [CFG_W-1:0] START_Y_RST = 4'd1;
    localparam logic [CFG_W-1:0] GOAL_X_RST  = 4'd8;
    localparam logic [CFG_W-1:0] GOAL_Y_RST  = 4'd8;

    // Start and goal coordinates handed to the search engine.
    typedef struct packed {
        logic [CFG_W-1:0] start_x;
        logic [CFG_W-1:0] start_y;
        logic [CFG_W-1:0] goal_x;
        logic [CFG_W-1:0] goal_y;
    } mpsd_cfg_t;

endpackage

### hw/rtl/mpsd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read in the same clocked block; read data is registered.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/mpsd_cfg.sv
`timescale 1ns / 1ps

// Start and goal registers behind the APB port.
module mpsd_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpsd_pkg::PADDR_W-1:0] paddr,
    input  logic [mpsd_pkg::PDATA_W-1:0] pwdata,
    output logic [mpsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output mpsd_pkg::mpsd_cfg_t          cfg
);

    mpsd_pkg::mpsd_cfg_t               cfg_reg;
    mpsd_pkg::mpsd_cfg_t               cfg_next;
    logic                              wr_en;
    logic [1:0]                        reg_idx;
    logic [mpsd_pkg::CFG_W-1:0]        wr_val;
    logic [mpsd_pkg::CFG_W-1:0]        rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[mpsd_pkg::PADDR_W-1:2];
    assign wr_val  = pwdata[mpsd_pkg::CFG_W-1:0];

    // Register update on the access cycle of a write.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                mpsd_pkg::REG_START_X: cfg_next.start_x = wr_val;
                mpsd_pkg::REG_START_Y: cfg_next.start_y = wr_val;
                mpsd_pkg::REG_GOAL_X:  cfg_next.goal_x  = wr_val;
                mpsd_pkg::REG_GOAL_Y:  cfg_next.goal_y  = wr_val;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x <= mpsd_pkg::START_X_RST;
            cfg_reg.start_y <= mpsd_pkg::START_Y_RST;
            cfg_reg.goal_x  <= mpsd_pkg::GOAL_X_RST;
            cfg_reg.goal_y  <= mpsd_pkg::GOAL_Y_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data follows the address.
    always_comb begin
        case (reg_idx)
            mpsd_pkg::REG_START_X: rd_val = cfg_reg.start_x;
            mpsd_pkg::REG_START_Y: rd_val = cfg_reg.start_y;
            mpsd_pkg::REG_GOAL_X:  rd_val = cfg_reg.goal_x;
            mpsd_pkg::REG_GOAL_Y:  rd_val = cfg_reg.goal_y;
            default:               rd_val = '0;
        endcase
    end

    assign prdata = mpsd_pkg::PDATA_W'(rd_val);
    assign cfg    = cfg_reg;

endmodule

### hw/rtl/mpsd_ctrl.sv
`timescale 1ns / 1ps

// Row loader, depth-first search sequencer and path readout.
// The map RAM holds one maze row per word, two bits per cell. The stack RAM
// holds one entry per path cell: {row, column, direction last tried}.
module mpsd_ctrl #(
    parameter int GRID        = mpsd_pkg::GRID_DEF,
    parameter int STACK_DEPTH = mpsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpsd_pkg::mpsd_cfg_t          cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mpsd_pkg::ROW_W-1:0]   s_row_bits,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mpsd_pkg::POS_W-1:0]   m_pos_x,
    output logic [mpsd_pkg::POS_W-1:0]   m_pos_y,
    output logic                         m_found,
    output logic                         m_last
);

    localparam int CW  = $clog2(GRID);
    localparam int PW  = ($clog2(GRID + 2) > mpsd_pkg::CFG_W) ?
                         $clog2(GRID + 2) : mpsd_pkg::CFG_W;
    localparam int LIM = (STACK_DEPTH < mpsd_pkg::MAX_RESULTS) ?
                         STACK_DEPTH : mpsd_pkg::MAX_RESULTS;
    localparam int CNW = $clog2(LIM + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int EW  = 2 * CW + 2;
    localparam int MW  = 2 * GRID;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PROBE    = 8'b0000_0010,
        S_CHECK    = 8'b0000_0100,
        S_POP_RD   = 8'b0000_1000,
        S_POP_CHK  = 8'b0001_0000,
        S_OUT_RD   = 8'b0010_0000,
        S_OUT_LOAD = 8'b0100_0000,
        S_OUT_HOLD = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               rows_reg, rows_next;
    logic [PW-1:0]               px_reg, px_next;
    logic [PW-1:0]               py_reg, py_next;
    logic [CNW-1:0]              cnt_reg, cnt_next;
    logic [CNW-1:0]              k_reg, k_next;
    logic                        ov_reg, ov_next;
    logic [mpsd_pkg::POS_W-1:0]  ox_reg, ox_next;
    logic [mpsd_pkg::POS_W-1:0]  oy_reg, oy_next;
    logic                        of_reg, of_next;
    logic                        ol_reg, ol_next;

    logic                        map_we;
    logic [CW-1:0]               map_waddr;
    logic [MW-1:0]               map_wdata;
    logic [MW-1:0]               map_rdata;
    logic [MW-1:0]               row_mark;
    logic                        stk_we;
    logic [SAW-1:0]              stk_waddr;
    logic [EW-1:0]               stk_wdata;
    logic [SAW-1:0]              stk_raddr;
    logic [EW-1:0]               stk_rdata;

    logic                        probe_in;
    logic [CW-1:0]               xi;
    logic [CW-1:0]               yi;
    logic [1:0]                  cell_code;
    logic                        push;
    logic                        at_goal;
    logic                        stk_empty;
    logic [CNW-1:0]              cnt_m1;
    logic [1:0]                  e_dir;
    logic [CW-1:0]               e_x;
    logic [CW-1:0]               e_y;
    logic [1:0]                  nd;
    logic [PW-1:0]               ex1;
    logic [PW-1:0]               ey1;
    logic [PW-1:0]               nx;
    logic [PW-1:0]               ny;
    logic                        go_miss;

    // Expand one input row into map cell codes; columns past bit 7 are open.
    function automatic logic [MW-1:0] row_word(input logic [mpsd_pkg::ROW_W-1:0] row);
        logic [MW-1:0] w;
        w = '0;
        for (int j = 0; j < GRID; j++) begin
            if (j < mpsd_pkg::ROW_W && row[j[2:0]]) begin
                w[2*j +: 2] = mpsd_pkg::CELL_WALL;
            end else begin
                w[2*j +: 2] = mpsd_pkg::CELL_OPEN;
            end
        end
        return w;
    endfunction

    // Map RAM: GRID rows of GRID two-bit cells.
    mpsd_ram #(
        .WIDTH (MW),
        .DEPTH (GRID)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (yi),
        .rdata (map_rdata)
    );

    // Stack RAM: one entry per cell on the current path.
    mpsd_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Probe decode. The map read issued in PROBE returns the probed row in CHECK.
    assign probe_in  = (px_reg >= PW'(1)) && (px_reg <= PW'(GRID)) &&
                       (py_reg >= PW'(1)) && (py_reg <= PW'(GRID));
    assign xi        = CW'(px_reg - PW'(1));
    assign yi        = CW'(py_reg - PW'(1));
    assign cell_code = map_rdata[{xi, 1'b0} +: 2];
    assign push      = (cell_code == mpsd_pkg::CELL_OPEN) && (cnt_reg < CNW'(LIM));
    assign at_goal   = (px_reg == PW'(cfg.goal_x)) && (py_reg == PW'(cfg.goal_y));
    assign stk_empty = (cnt_reg == '0);
    assign cnt_m1    = cnt_reg - CNW'(1);

    // Row with the probed cell marked visited, for the write-back.
    always_comb begin
        row_mark = map_rdata;
        row_mark[{xi, 1'b0} +: 2] = mpsd_pkg::CELL_VISITED;
    end

    // Stack entry decode and the next probe after a backtrack.
    assign e_dir = stk_rdata[1:0];
    assign e_x   = stk_rdata[CW+1:2];
    assign e_y   = stk_rdata[2*CW+1:CW+2];
    assign nd    = e_dir + 2'd1;
    assign ex1   = PW'(e_x) + PW'(1);
    assign ey1   = PW'(e_y) + PW'(1);

    always_comb begin
        case (nd)
            mpsd_pkg::DIR_SOUTH: begin
                nx = ex1;
                ny = ey1 + PW'(1);
            end
            mpsd_pkg::DIR_WEST: begin
                nx = ex1 - PW'(1);
                ny = ey1;
            end
            mpsd_pkg::DIR_NORTH: begin
                nx = ex1;
                ny = ey1 - PW'(1);
            end
            default: begin
                nx = ex1 + PW'(1);
                ny = ey1;
            end
        endcase
    end

    // Stack reads address the top entry, or the path cell being emitted.
    assign stk_raddr = (state_reg == S_OUT_RD) ? SAW'(k_reg) : SAW'(cnt_m1);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        rows_next  = rows_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        of_next    = of_reg;
        ol_next    = ol_reg;
        map_we     = 1'b0;
        map_waddr  = rows_reg;
        map_wdata  = row_word(s_row_bits);
        stk_we     = 1'b0;
        stk_waddr  = SAW'(cnt_reg);
        stk_wdata  = {yi, xi, mpsd_pkg::DIR_EAST};
        go_miss    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    map_we = 1'b1;
                    if (rows_reg == CW'(GRID - 1)) begin
                        rows_next  = '0;
                        px_next    = PW'(cfg.start_x);
                        py_next    = PW'(cfg.start_y);
                        cnt_next   = '0;
                        state_next = S_PROBE;
                    end else begin
                        rows_next = rows_reg + CW'(1);
                    end
                end
            end
            S_PROBE: begin
                if (probe_in) begin
                    state_next = S_CHECK;
                end else if (stk_empty) begin
                    go_miss = 1'b1;
                end else begin
                    state_next = S_POP_RD;
                end
            end
            S_CHECK: begin
                if (push) begin
                    // Mark the cell visited and push it with east as its first try.
                    map_we    = 1'b1;
                    map_waddr = yi;
                    map_wdata = row_mark;
                    stk_we    = 1'b1;
                    cnt_next  = cnt_reg + CNW'(1);
                    if (at_goal) begin
                        k_next     = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        px_next    = px_reg + PW'(1);
                        state_next = S_PROBE;
                    end
                end else if (stk_empty) begin
                    go_miss = 1'b1;
                end else begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD: begin
                state_next = S_POP_CHK;
            end
            S_POP_CHK: begin
                if (e_dir == mpsd_pkg::DIR_NORTH) begin
                    // Dead end: drop the entry. Its cell keeps the visited mark,
                    // which closes it to the search just as a wall mark would.
                    cnt_next = cnt_m1;
                    if (cnt_m1 == '0) begin
                        go_miss = 1'b1;
                    end else begin
                        state_next = S_POP_RD;
                    end
                end else begin
                    // Advance the top entry to its next direction and probe there.
                    stk_we     = 1'b1;
                    stk_waddr  = SAW'(cnt_m1);
                    stk_wdata  = {e_y, e_x, nd};
                    px_next    = nx;
                    py_next    = ny;
                    state_next = S_PROBE;
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                ox_next    = mpsd_pkg::POS_W'({1'b0, e_x} + 1'b1);
                oy_next    = mpsd_pkg::POS_W'({1'b0, e_y} + 1'b1);
                of_next    = 1'b1;
                ol_next    = (k_reg == cnt_m1);
                ov_next    = 1'b1;
                state_next = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (m_ready) begin
                    ov_next = 1'b0;
                    if (ol_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + CNW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // No path: a single beat with all fields clear but last.
        if (go_miss) begin
            ox_next    = '0;
            oy_next    = '0;
            of_next    = 1'b0;
            ol_next    = 1'b1;
            ov_next    = 1'b1;
            state_next = S_OUT_HOLD;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rows_reg  <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge aclk) begin
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        of_reg <= of_next;
        ol_reg <= ol_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = ov_reg;
    assign m_pos_x = ox_reg;
    assign m_pos_y = oy_reg;
    assign m_found = of_reg;
    assign m_last  = ol_reg;

    // The stack never holds more entries than a run may report.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNW'(LIM))
        else $error("path stack count above its limit");

    // Rows are taken only while no result beat is pending.
    a_in_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // A map check only follows a probe inside the grid.
    a_check_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> probe_in)
        else $error("map check on a probe outside the grid");

    // A push grows the stack by exactly one entry.
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && push) |=> (cnt_reg == $past(cnt_reg) + CNW'(1)))
        else $error("push did not advance the stack count");

    // The final beat returns the block to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (state_reg == S_IDLE))
        else $error("block not idle after the final result beat");

endmodule

### hw/rtl/maze_path_search_dfs.sv
// Row beats take one cycle each; the beat with the last maze row starts the search.
// Search: each cell probe runs PROBE then CHECK and each backtrack step runs POP_RD then
// POP_CHK, as the map and stack RAMs give registered read data; each result beat then
// runs OUT_RD, OUT_LOAD and OUT_HOLD, and waits in OUT_HOLD through any m_ready stall.
// Reset (aresetn low at a clock edge) clears control and sets start (1,1) and goal (8,8);
// RAMs are not cleared, since every search first rewrites the whole map.
`timescale 1ns / 1ps

module maze_path_search_dfs #(
    parameter int GRID        = mpsd_pkg::GRID_DEF,
    parameter int STACK_DEPTH = mpsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpsd_pkg::PADDR_W-1:0] paddr,
    input  logic [mpsd_pkg::PDATA_W-1:0] pwdata,
    output logic [mpsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mpsd_pkg::ROW_W-1:0]   s_row_bits,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mpsd_pkg::POS_W-1:0]   m_pos_x,
    output logic [mpsd_pkg::POS_W-1:0]   m_pos_y,
    output logic                         m_found,
    output logic                         m_last
);

    mpsd_pkg::mpsd_cfg_t cfg;

    // Start and goal registers.
    mpsd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Maze load, search and path readout.
    mpsd_ctrl #(
        .GRID        (GRID),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row_bits (s_row_bits),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .m_found    (m_found),
        .m_last     (m_last)
    );

endmodule
